### design/kcl_pkg.sv
package kcl_pkg;

  localparam int unsigned CODE_W = 16;
  localparam int unsigned KEY_W  = 4;
  localparam int unsigned MSG_W  = 3;
  localparam int unsigned STEP_W = 3;

  localparam int unsigned DEF_STORED_CODES = 16;

  localparam logic [CODE_W-1:0] RST_HOLD_TICKS   = 16'd2;
  localparam logic [CODE_W-1:0] RST_DEFAULT_CODE = 16'h1234;

  // configuration register indexes
  localparam logic REG_HOLD_TICKS   = 1'b0;
  localparam logic REG_DEFAULT_CODE = 1'b1;

  // key codes
  localparam logic [KEY_W-1:0] KEY_TEN   = 4'd10;
  localparam logic [KEY_W-1:0] KEY_STAR  = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH  = 4'd11;
  localparam logic [KEY_W-1:0] KEY_MULTI = 4'd12;

  // item kinds
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // messages
  localparam logic [MSG_W-1:0] MSG_NONE    = 3'd0;
  localparam logic [MSG_W-1:0] MSG_BAD     = 3'd1;
  localparam logic [MSG_W-1:0] MSG_GOOD    = 3'd2;
  localparam logic [MSG_W-1:0] MSG_VALID   = 3'd3;
  localparam logic [MSG_W-1:0] MSG_INVALID = 3'd4;
  localparam logic [MSG_W-1:0] MSG_SET     = 3'd5;
  localparam logic [MSG_W-1:0] MSG_ENTER   = 3'd6;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] ST_FETCH   = 3'd0;
  localparam logic [STEP_W-1:0] ST_APPLY   = 3'd1;
  localparam logic [STEP_W-1:0] ST_SCAN    = 3'd2;
  localparam logic [STEP_W-1:0] ST_RESOLVE = 3'd3;
  localparam logic [STEP_W-1:0] ST_EMIT    = 3'd4;
  localparam logic [STEP_W-1:0] ST_LAST    = ST_EMIT;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FETCH,
    OP_APPLY,
    OP_SCAN,
    OP_RESOLVE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_NO_MATCH,
    C_SCAN_BUSY,
    C_OUT_BUSY
  } cond_e;

  // one control word: datapath op, jump condition, jump target
  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_taken;
    logic need_match;
    logic scan_busy;
    logic out_busy;
  } status_t;

  // control store
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      ST_FETCH:   w = '{op: OP_FETCH,   cond: C_NO_INPUT,  target: ST_FETCH};
      ST_APPLY:   w = '{op: OP_APPLY,   cond: C_NO_MATCH,  target: ST_EMIT};
      ST_SCAN:    w = '{op: OP_SCAN,    cond: C_SCAN_BUSY, target: ST_SCAN};
      ST_RESOLVE: w = '{op: OP_RESOLVE, cond: C_NEVER,     target: ST_EMIT};
      ST_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT_BUSY,  target: ST_EMIT};
      default:    w = '{op: OP_NONE,    cond: C_NEVER,     target: ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

### design/kcl_if.sv
interface kcl_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [kcl_pkg::KEY_W-1:0] key_code;

  modport source (output valid, output cmd, output key_code, input ready);
  modport sink   (input valid, input cmd, input key_code, output ready);
endinterface

interface kcl_out_if #(
  parameter int unsigned CountW = 5
);
  logic                      valid;
  logic                      ready;
  logic [kcl_pkg::MSG_W-1:0] message;
  logic                      echo_valid;
  logic [kcl_pkg::KEY_W-1:0] echo_key;
  logic                      busy_res;
  logic [CountW-1:0]         stored_count;

  modport source (output valid, output message, output echo_valid, output echo_key,
                  output busy_res, output stored_count, input ready);
  modport sink   (input valid, input message, input echo_valid, input echo_key,
                  input busy_res, input stored_count, output ready);
endinterface

### design/kcl_seq.sv
module kcl_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kcl_pkg::status_t status_i,
  output kcl_pkg::ctrl_t   ctrl_o
);

  logic [kcl_pkg::STEP_W-1:0] step_q, step_d;
  logic                       jump;

  assign ctrl_o = kcl_pkg::ucode(step_q);

  always_comb begin
    unique case (ctrl_o.cond)
      kcl_pkg::C_NEVER:     jump = 1'b0;
      kcl_pkg::C_NO_INPUT:  jump = !status_i.in_taken;
      kcl_pkg::C_NO_MATCH:  jump = !status_i.need_match;
      kcl_pkg::C_SCAN_BUSY: jump = status_i.scan_busy;
      kcl_pkg::C_OUT_BUSY:  jump = status_i.out_busy;
      default:              jump = 1'b0;
    endcase
    priority if (jump) begin
      step_d = ctrl_o.target;
    end else if (step_q >= kcl_pkg::ST_LAST) begin
      step_d = kcl_pkg::ST_FETCH;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= kcl_pkg::ST_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  // the program never runs past its last word
  assert property (@(posedge clk_i) disable iff (!rst_ni) step_q <= kcl_pkg::ST_LAST)
    else $error("sequencer step out of program");

endmodule

### design/kcl_dp.sv
module kcl_dp #(
  parameter int unsigned STORED_CODES = kcl_pkg::DEF_STORED_CODES,
  parameter int unsigned CountW       = $clog2(STORED_CODES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kcl_pkg::ctrl_t              ctrl_i,
  output kcl_pkg::status_t            status_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [kcl_pkg::CODE_W-1:0]  cfg_data_i,
  kcl_in_if.sink                      in_ch,
  kcl_out_if.source                   out_ch
);

  localparam int unsigned AW = (STORED_CODES > 1) ? $clog2(STORED_CODES) : 1;
  localparam logic [CountW-1:0] FULL = CountW'(STORED_CODES);

  typedef enum logic [2:0] {
    M_D0,
    M_D1,
    M_D2,
    M_D3,
    M_PROG,
    M_HOLD
  } mode_e;

  // latched item
  logic                      cmd_q, cmd_d;
  logic [kcl_pkg::KEY_W-1:0] key_q, key_d;
  // lock state
  mode_e                      mode_q, mode_d;
  logic [kcl_pkg::CODE_W-1:0] entered_q, entered_d;
  logic                       star_q, star_d;
  logic [2:0]                 pc_q, pc_d;
  logic [kcl_pkg::CODE_W-1:0] new_q, new_d;
  logic [kcl_pkg::CODE_W-1:0] hold_q, hold_d;
  logic [CountW-1:0]          cnt_q, cnt_d;
  logic [kcl_pkg::CODE_W-1:0] hold_ticks_q, def_code_q;
  // scan unit
  logic [CountW-1:0]          a_q, a_d;
  logic                       p_q, p_d;
  logic                       hit_q, hit_d;
  logic                       hit_now;
  logic                       rd_en;
  logic [kcl_pkg::CODE_W-1:0] rd_q;
  logic                       mem_we;
  logic [kcl_pkg::CODE_W-1:0] mem [STORED_CODES];
  // pending result and output register
  logic [kcl_pkg::MSG_W-1:0]  rmsg_q, rmsg_d;
  logic                       rev_q, rev_d;
  logic [kcl_pkg::KEY_W-1:0]  rek_q, rek_d;
  logic                       ov_q, ov_d;
  logic [kcl_pkg::MSG_W-1:0]  omsg_q, omsg_d;
  logic                       oev_q, oev_d;
  logic [kcl_pkg::KEY_W-1:0]  oek_q, oek_d;
  logic                       obusy_q, obusy_d;
  logic [CountW-1:0]          ocnt_q, ocnt_d;

  logic                       is_digit;
  logic [kcl_pkg::CODE_W-1:0] shifted;

  assign is_digit = key_q < kcl_pkg::KEY_TEN;
  assign shifted  = {entered_q[kcl_pkg::CODE_W-5:0], key_q};
  assign hit_now  = hit_q || (p_q && (rd_q == entered_q));

  assign in_ch.ready         = (ctrl_i.op == kcl_pkg::OP_FETCH);
  assign status_o.in_taken   = in_ch.valid && in_ch.ready;
  assign status_o.need_match = (cmd_q == kcl_pkg::CMD_KEY) && (mode_q == M_D3) && is_digit;
  assign status_o.scan_busy  = !hit_now && ((a_q < cnt_q) || p_q);
  assign status_o.out_busy   = ov_q && !out_ch.ready;

  assign out_ch.valid        = ov_q;
  assign out_ch.message      = omsg_q;
  assign out_ch.echo_valid   = oev_q;
  assign out_ch.echo_key     = oek_q;
  assign out_ch.busy_res     = obusy_q;
  assign out_ch.stored_count = ocnt_q;

  always_comb begin
    cmd_d = cmd_q;       key_d = key_q;
    mode_d = mode_q;     entered_d = entered_q;
    star_d = star_q;     pc_d = pc_q;
    new_d = new_q;       hold_d = hold_q;
    cnt_d = cnt_q;
    a_d = a_q;           p_d = p_q;       hit_d = hit_q;
    rd_en = 1'b0;        mem_we = 1'b0;
    rmsg_d = rmsg_q;     rev_d = rev_q;   rek_d = rek_q;
    ov_d = ov_q && !out_ch.ready;
    omsg_d = omsg_q;     oev_d = oev_q;   oek_d = oek_q;
    obusy_d = obusy_q;   ocnt_d = ocnt_q;

    unique case (ctrl_i.op)
      kcl_pkg::OP_FETCH: begin
        if (in_ch.valid) begin
          cmd_d = in_ch.cmd;
          key_d = in_ch.key_code;
        end
      end
      kcl_pkg::OP_APPLY: begin
        rmsg_d = kcl_pkg::MSG_NONE;
        rev_d  = 1'b0;
        rek_d  = '0;
        if (cmd_q == kcl_pkg::CMD_TICK) begin
          if (mode_q == M_HOLD) begin
            if (hold_q <= 16'd1) begin
              hold_d    = '0;
              mode_d    = M_D0;
              star_d    = 1'b0;
              entered_d = '0;
              pc_d      = '0;
              rmsg_d    = kcl_pkg::MSG_ENTER;
            end else begin
              hold_d = hold_q - 1'b1;
            end
          end
        end else if (mode_q != M_HOLD && key_q < kcl_pkg::KEY_MULTI) begin
          unique case (mode_q)
            M_D0: begin
              if (key_q == kcl_pkg::KEY_HASH) begin
                rmsg_d = kcl_pkg::MSG_BAD;
                mode_d = M_HOLD;
                hold_d = hold_ticks_q;
              end else begin
                rev_d     = 1'b1;
                rek_d     = key_q;
                entered_d = {12'd0, key_q};
                star_d    = (key_q == kcl_pkg::KEY_STAR);
                mode_d    = M_D1;
              end
            end
            M_D1: begin
              if (star_q && key_q == kcl_pkg::KEY_STAR) begin
                rmsg_d = kcl_pkg::MSG_SET;
                mode_d = M_PROG;
                star_d = 1'b0;
                pc_d   = '0;
                new_d  = '0;
              end else if (is_digit && !star_q) begin
                rev_d     = 1'b1;
                rek_d     = key_q;
                entered_d = shifted;
                mode_d    = M_D2;
              end else begin
                rmsg_d = kcl_pkg::MSG_BAD;
                mode_d = M_HOLD;
                hold_d = hold_ticks_q;
              end
            end
            M_D2: begin
              if (is_digit) begin
                rev_d     = 1'b1;
                rek_d     = key_q;
                entered_d = shifted;
                mode_d    = M_D3;
              end else begin
                rmsg_d = kcl_pkg::MSG_BAD;
                mode_d = M_HOLD;
                hold_d = hold_ticks_q;
              end
            end
            M_D3: begin
              mode_d = M_HOLD;
              hold_d = hold_ticks_q;
              rmsg_d = kcl_pkg::MSG_BAD;
              if (is_digit) begin
                // full code known: start the table scan, default code checked here
                rev_d     = 1'b1;
                rek_d     = key_q;
                entered_d = shifted;
                hit_d     = (shifted == def_code_q);
                a_d       = '0;
                p_d       = 1'b0;
              end
            end
            M_PROG: begin
              rev_d = 1'b1;
              rek_d = key_q;
              if (pc_q >= 3'd4) begin
                // fifth key: only a hash after four clean digits stores, and only while the table has room
                if (!star_q && key_q == kcl_pkg::KEY_HASH && cnt_q < FULL) begin
                  mem_we = 1'b1;
                  cnt_d  = cnt_q + 1'b1;
                  rmsg_d = kcl_pkg::MSG_VALID;
                end else begin
                  rmsg_d = kcl_pkg::MSG_INVALID;
                end
                mode_d = M_HOLD;
                hold_d = hold_ticks_q;
                star_d = 1'b0;
                pc_d   = '0;
              end else begin
                if (!is_digit) begin
                  star_d = 1'b1;
                end else begin
                  new_d = {new_q[kcl_pkg::CODE_W-5:0], key_q};
                end
                pc_d = pc_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      kcl_pkg::OP_SCAN: begin
        hit_d = hit_now;
        if (a_q < cnt_q) begin
          rd_en = 1'b1;
          p_d   = 1'b1;
          a_d   = a_q + 1'b1;
        end else begin
          p_d = 1'b0;
        end
      end
      kcl_pkg::OP_RESOLVE: begin
        rmsg_d = hit_q ? kcl_pkg::MSG_GOOD : kcl_pkg::MSG_BAD;
      end
      kcl_pkg::OP_EMIT: begin
        if (!(ov_q && !out_ch.ready)) begin
          ov_d    = 1'b1;
          omsg_d  = rmsg_q;
          oev_d   = rev_q;
          oek_d   = rek_q;
          obusy_d = (mode_q == M_HOLD);
          ocnt_d  = cnt_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_D0;
      entered_q    <= '0;
      star_q       <= 1'b0;
      pc_q         <= '0;
      new_q        <= '0;
      hold_q       <= '0;
      cnt_q        <= '0;
      hold_ticks_q <= kcl_pkg::RST_HOLD_TICKS;
      def_code_q   <= kcl_pkg::RST_DEFAULT_CODE;
      a_q          <= '0;
      p_q          <= 1'b0;
      hit_q        <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      entered_q <= entered_d;
      star_q    <= star_d;
      pc_q      <= pc_d;
      new_q     <= new_d;
      hold_q    <= hold_d;
      cnt_q     <= cnt_d;
      a_q       <= a_d;
      p_q       <= p_d;
      hit_q     <= hit_d;
      ov_q      <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kcl_pkg::REG_HOLD_TICKS:   hold_ticks_q <= cfg_data_i;
          kcl_pkg::REG_DEFAULT_CODE: def_code_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    rmsg_q  <= rmsg_d;
    rev_q   <= rev_d;
    rek_q   <= rek_d;
    omsg_q  <= omsg_d;
    oev_q   <= oev_d;
    oek_q   <= oek_d;
    obusy_q <= obusy_d;
    ocnt_q  <= ocnt_d;
  end

  // code table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= new_q;
    end
    if (rd_en) begin
      rd_q <= mem[a_q[AW-1:0]];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FULL)
    else $error("stored code count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we |-> (cnt_q < FULL))
    else $error("code table written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (ctrl_i.op == kcl_pkg::OP_SCAN) |-> (mode_q == M_HOLD))
    else $error("table scan outside a held result");

endmodule

### design/keypad_code_lock_unit.sv
// keypad code lock
// in_ch carries one beat per key event (cmd 0, key_code) or time tick (cmd 1).
// out_ch returns exactly one result beat per input beat: message, echo of the
// key, whether a message is now held, and the number of stored user codes.
// cfg_we_i/cfg_idx_i/cfg_data_i write hold_ticks (index 0) and default_code
// (index 1); write only while no beat is in flight.
// an item runs through the steps fetch, apply and load of the output register;
// the load waits while the previous result beat is still held there
// a fourth digit in user mode adds a table scan, one stored code per cycle
// through the single read port of the code table, and a resolve step; the scan
// stops early on a hit, also on a hit with the default code
// one item is worked at a time, driven by a five-word microprogram
// the result sits in an output register: the next input beat is taken while
// it waits, and a stalled receiver only holds the following result back
// reset: entry state, no stored codes, hold_ticks 2, default_code 0x1234;
// no clearing pass, the table is only read below the stored count
module keypad_code_lock_unit #(
  parameter int unsigned STORED_CODES = kcl_pkg::DEF_STORED_CODES,
  parameter int unsigned CountW       = $clog2(STORED_CODES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kcl_in_if.sink                     in_ch,
  kcl_out_if.source                  out_ch,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [kcl_pkg::CODE_W-1:0] cfg_data_i
);

  // control word from the sequencer, flags back from the datapath
  kcl_pkg::ctrl_t   ctrl;
  kcl_pkg::status_t status;

  kcl_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // lock state, code table with scan unit, output register
  kcl_dp #(
    .STORED_CODES (STORED_CODES),
    .CountW       (CountW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

endmodule
